>>> rtl/hopfield_pkg.sv
// Shared types and constants for the Hopfield associative memory.
// No dependencies.
package hopfield_pkg;

    localparam int NEURONS_DEF      = 64;
    localparam int MAX_PATTERNS_DEF = 8;
    localparam int W_W              = 8;
    localparam int FIELD_W          = 11;
    localparam int ACC_W            = 18;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TRAIN = 2'd2,
        CMD_UPD   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic clear;
        logic train;
        logic shift;
    } cell_ctl_t;

endpackage

>>> rtl/hopfield_cell.sv
// One row of the weight store: a circular register of NEURONS weights.
// Depends on hopfield_pkg.
module hopfield_cell #(
    parameter int NEURONS      = hopfield_pkg::NEURONS_DEF,
    parameter int MAX_PATTERNS = hopfield_pkg::MAX_PATTERNS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hopfield_pkg::cell_ctl_t       ctl,
    input  logic                          row_bit,
    input  logic                          col_bit,
    input  logic signed [hopfield_pkg::W_W-1:0] acc_in,
    output logic signed [hopfield_pkg::W_W-1:0] acc_out,
    output logic                          sat
);
    import hopfield_pkg::*;

    localparam logic signed [W_W-1:0] WMAX = W_W'(MAX_PATTERNS);
    localparam logic signed [W_W:0]   WLIM = (W_W+1)'(MAX_PATTERNS);

    logic signed [W_W-1:0] w_reg [NEURONS];
    logic signed [W_W-1:0] head, trained;
    logic signed [W_W-1:0] prod;
    logic signed [W_W:0]   sum;

    assign head = w_reg[0];
    assign sum  = {head[W_W-1], head} + ((row_bit == col_bit) ? (W_W+1)'(1) : -(W_W+1)'(1));

    always_comb begin
        trained = sum[W_W-1:0];
        sat     = 1'b0;
        if (sum > WLIM) begin
            trained = WMAX;
            sat     = ctl.train;
        end else if (sum < -WLIM) begin
            trained = -WMAX;
            sat     = ctl.train;
        end
    end

    assign prod    = col_bit ? head : -head;
    assign acc_out = acc_in + prod;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            for (int k = 0; k < NEURONS; k++) w_reg[k] <= '0;
        end else if (ctl.shift) begin
            for (int k = 0; k < NEURONS - 1; k++) w_reg[k] <= w_reg[k+1];
            w_reg[NEURONS-1] <= ctl.train ? trained : head;
        end
    end
endmodule

>>> rtl/hopfield_associative_memory.sv
// Hopfield associative memory: an array of NEURONS row cells, each holding
// one weight row and rotating it one column per cycle. Depends on hopfield_pkg.
//
// Usage: one command per s_ beat (command, neuron, value); one m_ beat per
// command with neuron_index, neuron_value, local_field and overflow.
// Set and clear pass through RUN and FIN before m_valid rises in OUT. Train and update
// rotate every row once in RUN, then pass through FIN before m_valid rises.
// Weights stay symmetric, so an update walks the row of the addressed
// neuron across all columns and adds one weighted term per cycle.
// One command is in flight at a time; s_ready is high only in idle, so the
// next beat is accepted no earlier than the cycle after the result is taken.
// Reset (aresetn low, synchronous) zeroes all weights and neuron states.
// A stalled m_ready holds the result and blocks the next command.
module hopfield_associative_memory #(
    parameter int NEURONS      = hopfield_pkg::NEURONS_DEF,
    parameter int MAX_PATTERNS = hopfield_pkg::MAX_PATTERNS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_command,
    input  logic [5:0]                              s_neuron,
    input  logic                                    s_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [5:0]                              m_neuron_index,
    output logic                                    m_neuron_value,
    output logic signed [hopfield_pkg::FIELD_W-1:0] m_local_field,
    output logic                                    m_overflow
);
    import hopfield_pkg::*;

    localparam int CW = $clog2(NEURONS);

    state_t state_reg, state_next;
    logic [NEURONS-1:0] s_reg;
    logic [CW-1:0] col_reg;
    logic [1:0] cmd_reg;
    logic [5:0] n_reg;
    logic val_reg, ok_reg, ovf_reg;
    logic signed [ACC_W-1:0] field_reg;
    logic signed [W_W-1:0] chain [NEURONS+1];
    logic [NEURONS-1:0] sat_v;
    cell_ctl_t ctl;
    logic ok_in;
    logic [CW-1:0] n_idx;
    logic signed [W_W-1:0] fterm;

    assign ok_in = {26'd0, s_neuron} < 32'(NEURONS);
    assign s_ready = (state_reg == ST_IDLE);
    assign chain[0] = '0;
    assign n_idx = CW'(n_reg);

    always_comb begin
        ctl.clear = (state_reg == ST_RUN) && (cmd_reg == CMD_CLEAR);
        ctl.train = (cmd_reg == CMD_TRAIN);
        ctl.shift = (state_reg == ST_RUN) && (cmd_reg == CMD_TRAIN || cmd_reg == CMD_UPD);
    end

    for (genvar r = 0; r < NEURONS; r++) begin : g_row
        logic signed [W_W-1:0] a_in;
        assign a_in = '0;
        hopfield_cell #(.NEURONS(NEURONS), .MAX_PATTERNS(MAX_PATTERNS)) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .ctl(ctl), .row_bit(s_reg[r]), .col_bit(s_reg[col_reg]),
            .acc_in(a_in), .acc_out(chain[r+1]), .sat(sat_v[r])
        );
    end

    always_comb begin
        fterm = '0;
        for (int r = 0; r < NEURONS; r++) begin
            if (n_idx == CW'(r)) fterm = chain[r+1];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_RUN;
            ST_RUN:  if (cmd_reg == CMD_SET || cmd_reg == CMD_CLEAR ||
                         col_reg == CW'(NEURONS - 1)) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            s_reg     <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_valid) begin
                cmd_reg   <= s_command;
                n_reg     <= s_neuron;
                val_reg   <= s_value;
                ok_reg    <= ok_in;
                ovf_reg   <= 1'b0;
                field_reg <= '0;
                col_reg   <= '0;
            end
            if (state_reg == ST_RUN) begin
                col_reg <= col_reg + CW'(1);
                if (cmd_reg == CMD_TRAIN && |sat_v) ovf_reg <= 1'b1;
                if (cmd_reg == CMD_UPD && ok_reg)
                    field_reg <= field_reg + ACC_W'(fterm);
            end
            if (state_reg == ST_FIN && ok_reg) begin
                if (cmd_reg == CMD_SET) s_reg[n_idx] <= val_reg;
                if (cmd_reg == CMD_UPD) s_reg[n_idx] <= ~field_reg[ACC_W-1];
            end
        end
    end

    always_comb begin
        if (field_reg > ACC_W'(1023))       m_local_field = FIELD_W'(1023);
        else if (field_reg < -ACC_W'(1024)) m_local_field = -FIELD_W'(1024);
        else                                m_local_field = field_reg[FIELD_W-1:0];
    end

    assign m_valid        = (state_reg == ST_OUT);
    assign m_neuron_index = n_reg;
    assign m_neuron_value = ok_reg && s_reg[n_idx];
    assign m_overflow     = ovf_reg;
endmodule
